@@ rtl/core/mfse_pkg.sv @@
// ----------------------------------------------------------------------------
// Manchester frame symbol encoder package
// Shared types, codes and defaults for the encoder core and its parts.
// ----------------------------------------------------------------------------
package mfse_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 15;
    localparam int unsigned TICKS_W     = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNIT_TICKS    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRAILER_SHORT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRAILER_LONG  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_REPS   = 2'd3;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_DATA    = 2'd1;
    localparam logic [1:0] KIND_TRAILER = 2'd2;

    localparam logic [14:0] UNIT_TICKS_RST    = 15'd20;
    localparam logic [14:0] TRAILER_SHORT_RST = 15'd80;
    localparam logic [14:0] TRAILER_LONG_RST  = 15'd280;
    localparam logic [3:0]  HEADER_REPS_RST   = 4'd1;

    typedef struct packed {
        logic [14:0] unit_ticks;
        logic [14:0] trailer_short_ticks;
        logic [14:0] trailer_long_ticks;
        logic [3:0]  header_repeats;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       send_header;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_head;

endpackage

@@ rtl/core/mfse_if.sv @@
// ----------------------------------------------------------------------------
// Manchester frame symbol encoder channels
// Byte input, symbol output and configuration write channels.
// ----------------------------------------------------------------------------
interface mfse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mfse_out_if;
    logic        valid;
    logic        ready;
    logic        first_level;
    logic [15:0] first_ticks;
    logic        second_level;
    logic [15:0] second_ticks;
    logic [1:0]  symbol_kind;
    logic        last_of_run;

    modport source (output valid, output first_level, output first_ticks,
                    output second_level, output second_ticks, output symbol_kind,
                    output last_of_run, input ready);
    modport sink   (input valid, input first_level, input first_ticks,
                    input second_level, input second_ticks, input symbol_kind,
                    input last_of_run, output ready);
endinterface

interface mfse_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [mfse_pkg::CFG_INDEX_W-1:0]  index;
    logic [mfse_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/mfse_front.sv @@
// ----------------------------------------------------------------------------
// Manchester encoder front end
// Accepts frame bytes and marks the first byte of each frame for a header.
// ----------------------------------------------------------------------------
module mfse_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    mfse_in_if.sink            i_in,
    input  logic               i_q_full,
    output mfse_pkg::t_push    o_push
);

    logic r_in_frame;
    logic accept;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;

    always_comb begin
        o_push.valid             = accept;
        o_push.entry.data_byte   = i_in.data_byte;
        o_push.entry.last_byte   = i_in.last_byte;
        o_push.entry.send_header = !r_in_frame;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
        end else if (accept) begin
            r_in_frame <= !i_in.last_byte;
        end
    end

endmodule

@@ rtl/core/mfse_queue.sv @@
// ----------------------------------------------------------------------------
// Manchester encoder byte queue
// Short queue of classified bytes between the front end and the sequencer.
// ----------------------------------------------------------------------------
module mfse_queue #(
    parameter int unsigned DEPTH = mfse_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mfse_pkg::t_push    i_push,
    input  logic               i_pop,
    output mfse_pkg::t_head    o_head,
    output logic               o_full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    mfse_pkg::t_entry r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full       = (r_count == CNT_FULL);
    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd_ptr];
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/mfse_back.sv @@
// ----------------------------------------------------------------------------
// Manchester encoder symbol sequencer
// Expands queued bytes into data symbols, framed by header and trailer symbols.
// ----------------------------------------------------------------------------
module mfse_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mfse_pkg::t_cfg     i_cfg,
    input  mfse_pkg::t_head    i_head,
    output logic               o_pop,
    mfse_out_if.source         o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HEADER,
        S_DATA,
        S_TRAILER
    } t_state;

    t_state           r_state,  n_state;
    mfse_pkg::t_entry r_entry,  n_entry;
    logic [3:0]       r_rep,    n_rep;
    logic [1:0]       r_sub,    n_sub;
    logic [2:0]       r_bit,    n_bit;
    logic             r_valid,  n_valid;
    logic             r_l0,     n_l0;
    logic [15:0]      r_d0,     n_d0;
    logic             r_l1,     n_l1;
    logic [15:0]      r_d1,     n_d1;
    logic [1:0]       r_kind,   n_kind;
    logic             r_last,   n_last;

    logic        advance;
    logic        finish;
    logic        load;
    logic [15:0] u1;
    logic [15:0] u2;
    logic [3:0]  rep_last;

    assign u1       = {1'b0, i_cfg.unit_ticks};
    assign u2       = {i_cfg.unit_ticks, 1'b0};
    assign rep_last = i_cfg.header_repeats - 4'd1;
    assign advance  = !r_valid || o_out.ready;

    always_comb begin
        n_state = r_state;
        n_entry = r_entry;
        n_rep   = r_rep;
        n_sub   = r_sub;
        n_bit   = r_bit;
        n_valid = r_valid;
        n_l0    = r_l0;
        n_d0    = r_d0;
        n_l1    = r_l1;
        n_d1    = r_d1;
        n_kind  = r_kind;
        n_last  = r_last;
        finish  = 1'b0;

        if (advance) begin
            n_valid = (r_state != S_IDLE);
            unique case (r_state)
                S_IDLE: begin
                    finish = 1'b1;
                end
                S_HEADER: begin
                    n_l0   = 1'b1;
                    n_l1   = 1'b0;
                    n_kind = mfse_pkg::KIND_HEADER;
                    n_last = 1'b0;
                    n_d0   = (r_sub == 2'd1) ? u1 : u2;
                    n_d1   = (r_sub == 2'd0) ? u2 : u1;
                    if (r_sub == 2'd2) begin
                        n_sub = 2'd0;
                        if (r_rep == rep_last) begin
                            n_state = S_DATA;
                        end else begin
                            n_rep = r_rep + 4'd1;
                        end
                    end else begin
                        n_sub = r_sub + 2'd1;
                    end
                end
                S_DATA: begin
                    n_l0   = !r_entry.data_byte[r_bit];
                    n_l1   = r_entry.data_byte[r_bit];
                    n_d0   = u1;
                    n_d1   = u1;
                    n_kind = mfse_pkg::KIND_DATA;
                    n_last = (r_bit == 3'd7) && !r_entry.last_byte;
                    n_bit  = r_bit + 3'd1;
                    if (r_bit == 3'd7) begin
                        if (r_entry.last_byte) begin
                            n_state = S_TRAILER;
                        end else begin
                            finish = 1'b1;
                        end
                    end
                end
                S_TRAILER: begin
                    n_l0   = !r_entry.data_byte[7];
                    n_l1   = r_entry.data_byte[7];
                    n_d0   = {1'b0, i_cfg.trailer_short_ticks};
                    n_d1   = {1'b0, i_cfg.trailer_long_ticks};
                    n_kind = mfse_pkg::KIND_TRAILER;
                    n_last = 1'b1;
                    finish = 1'b1;
                end
                default: begin
                    finish = 1'b1;
                end
            endcase
        end

        load = finish && i_head.valid;
        if (finish) begin
            n_state = S_IDLE;
        end
        if (load) begin
            n_entry = i_head.entry;
            n_rep   = 4'd0;
            n_sub   = 2'd0;
            n_bit   = 3'd0;
            n_state = (i_head.entry.send_header && (i_cfg.header_repeats != 4'd0))
                      ? S_HEADER : S_DATA;
        end
    end

    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_entry <= n_entry;
        r_rep   <= n_rep;
        r_sub   <= n_sub;
        r_bit   <= n_bit;
        r_l0    <= n_l0;
        r_d0    <= n_d0;
        r_l1    <= n_l1;
        r_d1    <= n_d1;
        r_kind  <= n_kind;
        r_last  <= n_last;
    end

    assign o_out.valid        = r_valid;
    assign o_out.first_level  = r_l0;
    assign o_out.first_ticks  = r_d0;
    assign o_out.second_level = r_l1;
    assign o_out.second_ticks = r_d1;
    assign o_out.symbol_kind  = r_kind;
    assign o_out.last_of_run  = r_last;

endmodule

@@ rtl/core/manchester_frame_symbol_encoder_core.sv @@
// ----------------------------------------------------------------------------
// Manchester frame symbol encoder core
// Turns frame bytes into header, Manchester data and trailer pulse symbols.
// ----------------------------------------------------------------------------
//   Channel  Dir  Handshake     Carries
//   i_in     in   valid/ready   data_byte, last_byte
//   o_out    out  valid/ready   first/second level and ticks, kind, last_of_run
//   i_cfg    in   valid/ready   register index, write data (always ready)
//
// The sequencer sends one symbol per cycle unless stalled or idle: 8 data
// symbols per byte, 3 per header repeat at a frame start, 1 trailer at its end.
// A byte is accepted whenever the queue has room, while earlier bytes are
// still being expanded. Reset clears the queue, the frame flag and the output.
// A stalled output holds its symbol and the sequencer waits behind it.
// ----------------------------------------------------------------------------
module manchester_frame_symbol_encoder_core #(
    parameter int unsigned QUEUE_DEPTH = mfse_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mfse_in_if.sink     i_in,
    mfse_out_if.source  o_out,
    mfse_cfg_if.sink    i_cfg
);

    mfse_pkg::t_cfg  r_cfg;
    mfse_pkg::t_push push;
    mfse_pkg::t_head head;
    logic            q_full;
    logic            pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.unit_ticks          <= mfse_pkg::UNIT_TICKS_RST;
            r_cfg.trailer_short_ticks <= mfse_pkg::TRAILER_SHORT_RST;
            r_cfg.trailer_long_ticks  <= mfse_pkg::TRAILER_LONG_RST;
            r_cfg.header_repeats      <= mfse_pkg::HEADER_REPS_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                mfse_pkg::CFG_UNIT_TICKS:    r_cfg.unit_ticks          <= i_cfg.data;
                mfse_pkg::CFG_TRAILER_SHORT: r_cfg.trailer_short_ticks <= i_cfg.data;
                mfse_pkg::CFG_TRAILER_LONG:  r_cfg.trailer_long_ticks  <= i_cfg.data;
                mfse_pkg::CFG_HEADER_REPS:   r_cfg.header_repeats      <= i_cfg.data[3:0];
                default: begin
                end
            endcase
        end
    end

    mfse_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push)
    );

    mfse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full)
    );

    mfse_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

    a_trailer_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.symbol_kind == mfse_pkg::KIND_TRAILER) |-> o_out.last_of_run)
        else $error("trailer symbol without end of run");

    a_header_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.symbol_kind == mfse_pkg::KIND_HEADER) |-> !o_out.last_of_run)
        else $error("header symbol marked as end of run");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !i_in.ready)
        else $error("byte request taken while queue is full");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head.valid)
        else $error("sequencer loaded from an empty queue");

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// Manchester frame symbol encoder core testbench
// A planned list of bytes, register writes and pauses drives the byte and
// register channels, while a local encoder predicts every symbol. The symbol
// channel is checked field by field against that prediction, under random
// idling on both sides, one long output stall and a quiet final stretch.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned CYCLE_LIMIT   = 2_000_000;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned SETTLE_CYCLES = 64;
    localparam int unsigned RANDOM_BYTES  = 480;

    typedef enum logic [2:0] {
        STEP_BYTE,
        STEP_CFG,
        STEP_DRAIN,
        STEP_HOLD,
        STEP_CALM
    } t_step_kind;

    typedef struct packed {
        t_step_kind                       kind;
        logic [7:0]                       data_byte;
        logic                             last_byte;
        logic [mfse_pkg::CFG_INDEX_W-1:0] reg_index;
        logic [mfse_pkg::CFG_DATA_W-1:0]  reg_value;
    } t_step;

    typedef struct packed {
        logic        first_level;
        logic [15:0] first_ticks;
        logic        second_level;
        logic [15:0] second_ticks;
        logic [1:0]  symbol_kind;
        logic        last_of_run;
    } t_symbol;

    logic clk = 1'b0;
    logic rst_n;

    mfse_in_if  in_ch ();
    mfse_out_if out_ch ();
    mfse_cfg_if cfg_ch ();

    manchester_frame_symbol_encoder_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #6 clk = ~clk;

    t_step       plan[$];
    t_symbol     expected_symbols[$];

    logic [14:0] unit_q;
    logic [14:0] short_q;
    logic [14:0] long_q;
    logic [3:0]  repeats_q;
    logic        frame_open;

    bit          in_acc;
    bit          cfg_acc;
    bit          calm = 1'b0;
    int          gap_left = 0;
    int          hold_left = 0;
    int          burst_left = 0;
    int          hold_requests = 0;
    int          hold_served = 0;
    int          fails = 0;
    int          cycles = 0;
    int          settle = 0;

    function automatic void add_byte(input logic [7:0] b, input logic last);
        t_step s;
        s = '0;
        s.kind      = STEP_BYTE;
        s.data_byte = b;
        s.last_byte = last;
        plan.push_back(s);
    endfunction

    function automatic void add_mark(input t_step_kind kind);
        t_step s;
        s = '0;
        s.kind = kind;
        plan.push_back(s);
    endfunction

    function automatic void add_write(input logic [mfse_pkg::CFG_INDEX_W-1:0] idx,
                                      input logic [mfse_pkg::CFG_DATA_W-1:0] value);
        t_step s;
        s = '0;
        s.kind      = STEP_CFG;
        s.reg_index = idx;
        s.reg_value = value;
        plan.push_back(s);
    endfunction

    function automatic void add_settings(input logic [14:0] unit, input logic [14:0] t_short,
                                         input logic [14:0] t_long, input logic [3:0] reps);
        add_mark(STEP_DRAIN);
        add_write(mfse_pkg::CFG_UNIT_TICKS, unit);
        add_write(mfse_pkg::CFG_TRAILER_SHORT, t_short);
        add_write(mfse_pkg::CFG_TRAILER_LONG, t_long);
        add_write(mfse_pkg::CFG_HEADER_REPS, {11'd0, reps});
    endfunction

    function automatic t_symbol make_symbol(input logic l0, input logic [15:0] d0,
                                            input logic l1, input logic [15:0] d1,
                                            input logic [1:0] kind);
        t_symbol s;
        s.first_level  = l0;
        s.first_ticks  = d0;
        s.second_level = l1;
        s.second_ticks = d1;
        s.symbol_kind  = kind;
        s.last_of_run  = 1'b0;
        return s;
    endfunction

    // Expands one byte into the symbols it should cause and queues them.
    function automatic void expand_byte(input logic [7:0] b, input logic last);
        t_symbol     run[$];
        t_symbol     s;
        logic [15:0] u;
        logic [15:0] u2;
        u  = {1'b0, unit_q};
        u2 = u << 1;
        if (!frame_open) begin
            for (int r = 0; r < repeats_q; r++) begin
                run.push_back(make_symbol(1'b1, u2, 1'b0, u2, mfse_pkg::KIND_HEADER));
                run.push_back(make_symbol(1'b1, u, 1'b0, u, mfse_pkg::KIND_HEADER));
                run.push_back(make_symbol(1'b1, u2, 1'b0, u, mfse_pkg::KIND_HEADER));
            end
        end
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                run.push_back(make_symbol(1'b0, u, 1'b1, u, mfse_pkg::KIND_DATA));
            end else begin
                run.push_back(make_symbol(1'b1, u, 1'b0, u, mfse_pkg::KIND_DATA));
            end
        end
        if (last) begin
            run.push_back(make_symbol(~b[7], {1'b0, short_q}, b[7], {1'b0, long_q},
                                      mfse_pkg::KIND_TRAILER));
        end
        frame_open = !last;
        s = run[run.size()-1];
        s.last_of_run = 1'b1;
        run[run.size()-1] = s;
        foreach (run[i]) begin
            expected_symbols.push_back(run[i]);
        end
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    initial begin
        int         total;
        int         flen;
        bit         calm_planned;
        logic [3:0] reps;
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.data_byte    = '0;
        in_ch.last_byte    = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = mfse_pkg::CFG_UNIT_TICKS;
        cfg_ch.data        = '0;
        out_ch.ready       = 1'b0;

        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h80, 1'b1);
        add_byte(8'h7F, 1'b1);
        add_settings(15'd0, 15'd0, 15'd0, 4'd0);
        add_byte(8'hA5, 1'b0);
        add_byte(8'h5A, 1'b1);
        add_settings(15'h7FFF, 15'h7FFF, 15'h7FFF, 4'd15);
        add_byte(8'hFF, 1'b1);
        add_byte(8'h00, 1'b0);
        add_byte(8'h81, 1'b1);
        add_settings(15'd1, 15'h2AAA, 15'h5555, 4'd2);
        add_byte(8'h55, 1'b0);
        add_settings(15'd3, 15'h5555, 15'h2AAA, 4'd1);
        add_byte(8'hAA, 1'b1);

        total        = 0;
        calm_planned = 1'b0;
        for (int phase = 0; total < RANDOM_BYTES; phase++) begin
            reps = ($urandom % 4 == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 3));
            add_settings(($urandom % 2) ? 15'($urandom_range(0, 63)) : 15'($urandom),
                         15'($urandom), 15'($urandom), reps);
            if (phase == 1) begin
                add_mark(STEP_HOLD);
            end
            for (int n = 0; n < 60 && total < RANDOM_BYTES; ) begin
                if (!calm_planned && total - n + 60 >= RANDOM_BYTES) begin
                    add_mark(STEP_CALM);
                    calm_planned = 1'b1;
                end
                if ($urandom % 5 == 0) begin
                    add_byte(8'($urandom), 1'($urandom));
                    n++;
                    total++;
                end else begin
                    flen = $urandom_range(1, 6);
                    for (int k = 0; k < flen; k++) begin
                        add_byte(8'($urandom), k == flen - 1);
                    end
                    n     += flen;
                    total += flen;
                end
            end
        end

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
    end

    // Request driver: bytes and register writes leave the plan in order.
    always @(negedge clk) begin
        logic  in_next;
        logic  cfg_next;
        t_step s;
        if (rst_n) begin
            in_next  = in_ch.valid && !in_acc;
            cfg_next = cfg_ch.valid && !cfg_acc;
            if (!in_next && !cfg_next) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (plan.size() > 0) begin
                    s = plan[0];
                    case (s.kind)
                        STEP_BYTE: begin
                            void'(plan.pop_front());
                            in_ch.data_byte <= s.data_byte;
                            in_ch.last_byte <= s.last_byte;
                            in_next = 1'b1;
                            if (!calm && $urandom % 4 == 0) begin
                                gap_left = $urandom_range(1, 16);
                            end
                        end
                        STEP_CFG: begin
                            void'(plan.pop_front());
                            cfg_ch.index <= s.reg_index;
                            cfg_ch.data  <= s.reg_value;
                            cfg_next = 1'b1;
                        end
                        STEP_DRAIN: begin
                            if (expected_symbols.size() == 0) begin
                                void'(plan.pop_front());
                            end
                        end
                        STEP_HOLD: begin
                            void'(plan.pop_front());
                            hold_requests <= hold_requests + 1;
                        end
                        default: begin
                            void'(plan.pop_front());
                            calm <= 1'b1;
                        end
                    endcase
                end
            end
            in_ch.valid  <= in_next;
            cfg_ch.valid <= cfg_next;
        end
    end

    // Symbol receiver: random ready bursts, and one long stall on request.
    always @(negedge clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else if (calm) begin
            out_ch.ready <= 1'b1;
        end else if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            out_ch.ready <= ($urandom % 3 != 0);
        end
    end

    always @(posedge clk) begin
        t_symbol got;
        t_symbol want;
        in_acc  = 1'b0;
        cfg_acc = 1'b0;
        if (!rst_n) begin
            unit_q     = mfse_pkg::UNIT_TICKS_RST;
            short_q    = mfse_pkg::TRAILER_SHORT_RST;
            long_q     = mfse_pkg::TRAILER_LONG_RST;
            repeats_q  = mfse_pkg::HEADER_REPS_RST;
            frame_open = 1'b0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                cfg_acc = 1'b1;
                case (cfg_ch.index)
                    mfse_pkg::CFG_UNIT_TICKS:    unit_q    = cfg_ch.data;
                    mfse_pkg::CFG_TRAILER_SHORT: short_q   = cfg_ch.data;
                    mfse_pkg::CFG_TRAILER_LONG:  long_q    = cfg_ch.data;
                    mfse_pkg::CFG_HEADER_REPS:   repeats_q = cfg_ch.data[3:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                in_acc = 1'b1;
                expand_byte(in_ch.data_byte, in_ch.last_byte);
            end
            if (out_ch.valid && out_ch.ready) begin
                got.first_level  = out_ch.first_level;
                got.first_ticks  = out_ch.first_ticks;
                got.second_level = out_ch.second_level;
                got.second_ticks = out_ch.second_ticks;
                got.symbol_kind  = out_ch.symbol_kind;
                got.last_of_run  = out_ch.last_of_run;
                if (expected_symbols.size() == 0) begin
                    $error("symbol received while none was expected");
                    fails++;
                end else begin
                    want = expected_symbols.pop_front();
                    check_field("first_level", want.first_level, got.first_level);
                    check_field("first_ticks", want.first_ticks, got.first_ticks);
                    check_field("second_level", want.second_level, got.second_level);
                    check_field("second_ticks", want.second_ticks, got.second_ticks);
                    check_field("symbol_kind", want.symbol_kind, got.symbol_kind);
                    check_field("last_of_run", want.last_of_run, got.last_of_run);
                end
            end
        end
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else if (rst_n && plan.size() == 0 && !in_ch.valid && !cfg_ch.valid
                     && expected_symbols.size() == 0) begin
            settle++;
            if (settle == SETTLE_CYCLES) begin
                if (fails == 0) begin
                    $display("TB_OK");
                end else begin
                    $display("TB_ERROR");
                end
                $finish;
            end
        end else begin
            settle = 0;
        end
    end

endmodule
